// ===== sv/lmpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_pkg
// Shared constants, types and the quarter-wave sine table for the plane-wave
// phase insertion unit.
// ----------------------------------------------------------------------------
package lmpi_pkg;

   localparam int COMP_BITS    = 16;
   localparam int PHASE_BITS   = 12;
   localparam int COORD_BITS   = 6;
   localparam int NCOLOR       = 3;
   localparam int NAXIS        = 3;
   localparam int FRAC         = 14;
   localparam int MOM_BITS     = 6;
   localparam int EXT_BITS     = 7;
   localparam int SLICE_BITS   = 7;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 7;

   localparam int ADDR_BITS = PHASE_BITS - 2;
   localparam int QTR       = 1 << ADDR_BITS;
   localparam int ROM_BITS  = FRAC + 1;            // 0 .. 2^FRAC
   localparam int TRIG_BITS = FRAC + 2;            // signed +-2^FRAC
   localparam int PROD_BITS = COMP_BITS + TRIG_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   // |mom * coord| < 2^(MOM_BITS-1) * 2^COORD_BITS
   localparam int MAG_BITS      = MOM_BITS + COORD_BITS - 1;
   localparam int FRAC_STEPS    = PHASE_BITS + 1;
   localparam int DIV_STEPS     = MAG_BITS + FRAC_STEPS;
   localparam int STEPS_PER_STG = 4;
   localparam int DIV_STAGES    = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

   // pipeline stage numbers
   localparam int STG_MULT = 1;
   localparam int STG_DIV0 = 2;
   localparam int STG_TERM = STG_DIV0 + DIV_STAGES;
   localparam int STG_SUM  = STG_TERM + 1;
   localparam int STG_ROM  = STG_SUM + 1;
   localparam int STG_PROD = STG_ROM + 1;
   localparam int STG_OUT  = STG_PROD + 1;
   localparam int NSTG     = STG_OUT;

   localparam logic [FRAC_STEPS:0] NEG_BASE = (FRAC_STEPS + 1)'((1 << FRAC_STEPS) + 1);
   localparam logic [EXT_BITS-1:0] EXTENT_RESET = EXT_BITS'(64);

   localparam logic [CSR_IDX_BITS-1:0] REG_MOM_X      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MOM_Y      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MOM_Z      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_X   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_Y   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXTENT_Z   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_SRC_SLICE  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_ALL_SLICES = 3'd7;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (FRAC - 1));
   localparam logic signed [SUM_BITS-1:0] COMP_MAX =
      SUM_BITS'({1'b0, {(COMP_BITS - 1){1'b1}}});
   localparam logic signed [SUM_BITS-1:0] COMP_MIN = -COMP_MAX - SUM_BITS'(1);

   typedef logic [ROM_BITS-1:0] sine_rom_type [0:QTR];

   // shift-subtract quotient, elaboration only
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q30 Taylor series, evaluated at elaboration only
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned dv;
      longint          sum;
      longint          q;
      for (int k = 0; k <= QTR; k++) begin
         x    = (HALFPI_Q30 * 64'(k)) >> ADDR_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 12; n++) begin
            term = (term * x2) >> 30;
            dv   = 64'(2 * n) * 64'(2 * n + 1);
            term = udiv64(term, dv);
            if ((n & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         q = (sum + 64'sd32768) >>> 16;
         if (q > (64'sd1 << FRAC)) q = 64'sd1 << FRAC;
         rom[k] = q[ROM_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // round half up from Q2.28 to Q1.14, then clamp
   function automatic logic signed [COMP_BITS-1:0] sat_round(
      input logic signed [SUM_BITS-1:0] s);
      logic signed [SUM_BITS-1:0] r;
      r = (s + ROUND_HALF) >>> FRAC;
      if (r > COMP_MAX) r = COMP_MAX;
      if (r < COMP_MIN) r = COMP_MIN;
      return r[COMP_BITS-1:0];
   endfunction

endpackage

// ===== sv/lattice_momentum_phase_insert_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_momentum_phase_insert_unit
// Multiplies a three-color vector by a plane-wave phase on a chosen slice or on every slice.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one lattice site (x, y, z, t and three complex colors) per
//   word; rsp_* returns the rotated (or unchanged) vector, one word per site.
//   csr_* writes momentum, extents and slice select; write only when idle.
//   Throughput is one word per cycle while the receiver takes words. Depth
//   is set by the 24-step remainder and fraction division in each axis lane
//   (four steps per stage, six stages), plus multiply, term, phase sum,
//   table read, product and output stages.
//   Every stage holds a valid bit and moves when the next one is free, so
//   words close up bubbles behind a stalled receiver; req_ready drops only
//   once all 12 stages hold words and rsp_ready is low.
//   Reset empties the pipeline and restores the registers: zero momentum,
//   extents 64, slice 0, all_slices off.
// ----------------------------------------------------------------------------
module lattice_momentum_phase_insert_unit
   import lmpi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_wen,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [COORD_BITS-1:0]        req_coord_x,
   input  logic [COORD_BITS-1:0]        req_coord_y,
   input  logic [COORD_BITS-1:0]        req_coord_z,
   input  logic [SLICE_BITS-1:0]        req_coord_t,
   input  logic signed [COMP_BITS-1:0]  req_in_re0,
   input  logic signed [COMP_BITS-1:0]  req_in_im0,
   input  logic signed [COMP_BITS-1:0]  req_in_re1,
   input  logic signed [COMP_BITS-1:0]  req_in_im1,
   input  logic signed [COMP_BITS-1:0]  req_in_re2,
   input  logic signed [COMP_BITS-1:0]  req_in_im2,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COMP_BITS-1:0]  rsp_out_re0,
   output logic signed [COMP_BITS-1:0]  rsp_out_im0,
   output logic signed [COMP_BITS-1:0]  rsp_out_re1,
   output logic signed [COMP_BITS-1:0]  rsp_out_im1,
   output logic signed [COMP_BITS-1:0]  rsp_out_re2,
   output logic signed [COMP_BITS-1:0]  rsp_out_im2
);

   logic signed [MOM_BITS-1:0] mom_x_ff, mom_y_ff, mom_z_ff;
   logic [EXT_BITS-1:0]        extent_x_ff, extent_y_ff, extent_z_ff;
   logic [SLICE_BITS-1:0]      source_slice_ff;
   logic                       all_slices_ff;

   logic [NSTG:1] stage_en;
   logic [NSTG:1] valid_ff;
   logic [NSTG:1] valid_src;
   logic [NSTG:1] valid_in;

   logic                        apply_in;
   logic signed [COMP_BITS-1:0] req_comp [2*NCOLOR];
   logic signed [COMP_BITS-1:0] comp_ff  [STG_MULT:STG_ROM][2*NCOLOR];
   logic                        apply_ff [STG_MULT:STG_ROM];

   logic signed [MOM_BITS-1:0]   mom    [NAXIS];
   logic [EXT_BITS-1:0]          extent [NAXIS];
   logic [COORD_BITS-1:0]        coord  [NAXIS];
   logic [PHASE_BITS-1:0]        term   [NAXIS];
   logic signed [TRIG_BITS-1:0]  cos_val, sin_val;
   logic signed [COMP_BITS-1:0]  out_comp [2*NCOLOR];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mom_x_ff        <= '0;
         mom_y_ff        <= '0;
         mom_z_ff        <= '0;
         extent_x_ff     <= EXTENT_RESET;
         extent_y_ff     <= EXTENT_RESET;
         extent_z_ff     <= EXTENT_RESET;
         source_slice_ff <= '0;
         all_slices_ff   <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_MOM_X:      mom_x_ff        <= csr_wdata[MOM_BITS-1:0];
            REG_MOM_Y:      mom_y_ff        <= csr_wdata[MOM_BITS-1:0];
            REG_MOM_Z:      mom_z_ff        <= csr_wdata[MOM_BITS-1:0];
            REG_EXTENT_X:   extent_x_ff     <= csr_wdata[EXT_BITS-1:0];
            REG_EXTENT_Y:   extent_y_ff     <= csr_wdata[EXT_BITS-1:0];
            REG_EXTENT_Z:   extent_z_ff     <= csr_wdata[EXT_BITS-1:0];
            REG_SRC_SLICE:  source_slice_ff <= csr_wdata[SLICE_BITS-1:0];
            REG_ALL_SLICES: all_slices_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage moves when empty or when the stage after it moves
   always_comb begin
      stage_en[NSTG] = !valid_ff[NSTG] || rsp_ready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign valid_src = {valid_ff[NSTG-1:1], req_valid};
   assign valid_in  = (stage_en & valid_src) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   assign req_ready = stage_en[STG_MULT];
   assign rsp_valid = valid_ff[NSTG];

   assign apply_in = (all_slices_ff || req_coord_t == source_slice_ff) &&
                     (mom_x_ff != '0 || mom_y_ff != '0 || mom_z_ff != '0);

   assign req_comp[0] = req_in_re0;
   assign req_comp[1] = req_in_im0;
   assign req_comp[2] = req_in_re1;
   assign req_comp[3] = req_in_im1;
   assign req_comp[4] = req_in_re2;
   assign req_comp[5] = req_in_im2;

   // vector and apply flag ride alongside the phase pipeline
   for (genvar i = STG_MULT; i <= STG_ROM; i++) begin : g_carry
      if (i == STG_MULT) begin : g_head
         always_ff @(posedge clock) begin
            if (stage_en[i]) begin
               comp_ff[i]  <= req_comp;
               apply_ff[i] <= apply_in;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (stage_en[i]) begin
               comp_ff[i]  <= comp_ff[i-1];
               apply_ff[i] <= apply_ff[i-1];
            end
         end
      end
   end

   assign mom[0]    = mom_x_ff;
   assign mom[1]    = mom_y_ff;
   assign mom[2]    = mom_z_ff;
   assign extent[0] = extent_x_ff;
   assign extent[1] = extent_y_ff;
   assign extent[2] = extent_z_ff;
   assign coord[0]  = req_coord_x;
   assign coord[1]  = req_coord_y;
   assign coord[2]  = req_coord_z;

   for (genvar a = 0; a < NAXIS; a++) begin : g_axis
      lmpi_axis_lane u_axis (
         .clock    (clock),
         .stage_en (stage_en),
         .mom      (mom[a]),
         .extent   (extent[a]),
         .coord    (coord[a]),
         .term     (term[a])
      );
   end

   lmpi_phase_merge u_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .term     (term),
      .cos_val  (cos_val),
      .sin_val  (sin_val)
   );

   for (genvar c = 0; c < NCOLOR; c++) begin : g_color
      lmpi_color_lane u_color (
         .clock    (clock),
         .stage_en (stage_en),
         .apply    (apply_ff[STG_ROM]),
         .in_re    (comp_ff[STG_ROM][2*c]),
         .in_im    (comp_ff[STG_ROM][2*c+1]),
         .cos_val  (cos_val),
         .sin_val  (sin_val),
         .out_re   (out_comp[2*c]),
         .out_im   (out_comp[2*c+1])
      );
   end

   assign rsp_out_re0 = out_comp[0];
   assign rsp_out_im0 = out_comp[1];
   assign rsp_out_re1 = out_comp[2];
   assign rsp_out_im1 = out_comp[3];
   assign rsp_out_re2 = out_comp[4];
   assign rsp_out_im2 = out_comp[5];

endmodule

// ===== sv/lmpi_axis_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_axis_lane
// Phase term of one axis: mom*coord, remainder and fraction by a pipelined
// restoring division against the extent, then round to PHASE_BITS.
// ----------------------------------------------------------------------------
module lmpi_axis_lane
   import lmpi_pkg::*;
(
   input  logic                        clock,
   input  logic [NSTG:1]               stage_en,
   input  logic signed [MOM_BITS-1:0]  mom,
   input  logic [EXT_BITS-1:0]         extent,
   input  logic [COORD_BITS-1:0]       coord,
   output logic [PHASE_BITS-1:0]       term
);

   logic signed [MOM_BITS+COORD_BITS:0] prod;
   logic signed [MOM_BITS+COORD_BITS:0] prod_abs;
   logic [MAG_BITS-1:0]   mag_ff;
   logic                  neg_ff;

   logic [EXT_BITS-1:0]   rem_ff [DIV_STAGES];
   logic [FRAC_STEPS-1:0] q_ff   [DIV_STAGES];
   logic [MAG_BITS-1:0]   magp_ff [DIV_STAGES];
   logic                  negp_ff [DIV_STAGES];

   logic [FRAC_STEPS:0]   up;
   logic                  remnz;
   logic [PHASE_BITS-1:0] term_in;
   logic [PHASE_BITS-1:0] term_ff;

   assign prod     = mom * $signed({1'b0, coord});
   assign prod_abs = prod[MOM_BITS+COORD_BITS] ? -prod : prod;

   always_ff @(posedge clock) begin
      if (stage_en[STG_MULT]) begin
         mag_ff <= prod_abs[MAG_BITS-1:0];
         neg_ff <= prod[MOM_BITS+COORD_BITS];
      end
   end

   // Each step shifts one dividend bit into the remainder; once the magnitude
   // bits run out zeros follow and the quotient bits become the fraction.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [EXT_BITS-1:0]   rem_src;
      logic [FRAC_STEPS-1:0] q_src;
      logic [MAG_BITS-1:0]   mag_src;
      logic                  neg_src;
      logic [EXT_BITS-1:0]   rem_in;
      logic [FRAC_STEPS-1:0] q_in;
      logic [MAG_BITS-1:0]   mag_in;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign q_src   = '0;
         assign mag_src = mag_ff;
         assign neg_src = neg_ff;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign mag_src = magp_ff[s-1];
         assign neg_src = negp_ff[s-1];
      end

      always_comb begin
         logic [EXT_BITS:0] trial;
         logic              qbit;
         rem_in = rem_src;
         q_in   = q_src;
         mag_in = mag_src;
         for (int k = 0; k < STEPS_PER_STG; k++) begin
            if (s * STEPS_PER_STG + k < DIV_STEPS) begin
               trial  = {rem_in, mag_in[MAG_BITS-1]};
               mag_in = {mag_in[MAG_BITS-2:0], 1'b0};
               qbit   = (trial >= {1'b0, extent});
               if (qbit) rem_in = EXT_BITS'(trial - {1'b0, extent});
               else rem_in = trial[EXT_BITS-1:0];
               q_in = {q_in[FRAC_STEPS-2:0], qbit};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[STG_DIV0+s]) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            magp_ff[s] <= mag_in;
            negp_ff[s] <= neg_src;
         end
      end
   end

   // positive: (q+1)/2; negative: (2^13 + 1 - ceil(frac))/2
   assign remnz = (rem_ff[DIV_STAGES-1] != '0);

   always_comb begin
      if (!negp_ff[DIV_STAGES-1]) begin
         up = {1'b0, q_ff[DIV_STAGES-1]} + (FRAC_STEPS + 1)'(1);
      end else begin
         up = NEG_BASE - {1'b0, q_ff[DIV_STAGES-1]} - {{FRAC_STEPS{1'b0}}, remnz};
      end
      if (extent == '0) begin
         term_in = '0;
      end else if (negp_ff[DIV_STAGES-1] && q_ff[DIV_STAGES-1] == '0 && !remnz) begin
         term_in = '0;
      end else begin
         term_in = up[PHASE_BITS:1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_TERM]) term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

// ===== sv/lmpi_phase_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_phase_merge
// Adds the axis terms modulo one turn and looks up cosine and sine from the
// quarter-wave table.
// ----------------------------------------------------------------------------
module lmpi_phase_merge
   import lmpi_pkg::*;
(
   input  logic                         clock,
   input  logic [NSTG:1]                stage_en,
   input  logic [PHASE_BITS-1:0]        term [NAXIS],
   output logic signed [TRIG_BITS-1:0]  cos_val,
   output logic signed [TRIG_BITS-1:0]  sin_val
);

   logic [PHASE_BITS-1:0] ph_in;
   logic [1:0]            quad_ff;
   logic [ADDR_BITS-1:0]  idx_ff;
   logic [ADDR_BITS:0]    lo_addr;
   logic [ADDR_BITS:0]    hi_addr;
   logic [1:0]            quad_rd_ff;
   logic [ROM_BITS-1:0]   lo_ff;
   logic [ROM_BITS-1:0]   hi_ff;
   logic signed [TRIG_BITS-1:0] lo_s;
   logic signed [TRIG_BITS-1:0] hi_s;

   assign ph_in = term[0] + term[1] + term[2];

   always_ff @(posedge clock) begin
      if (stage_en[STG_SUM]) begin
         quad_ff <= ph_in[PHASE_BITS-1 -: 2];
         idx_ff  <= ph_in[ADDR_BITS-1:0];
      end
   end

   assign lo_addr = {1'b0, idx_ff};
   assign hi_addr = (ADDR_BITS + 1)'(QTR) - {1'b0, idx_ff};

   always_ff @(posedge clock) begin
      if (stage_en[STG_ROM]) begin
         lo_ff      <= SINE_ROM[lo_addr];
         hi_ff      <= SINE_ROM[hi_addr];
         quad_rd_ff <= quad_ff;
      end
   end

   assign lo_s = $signed({1'b0, lo_ff});
   assign hi_s = $signed({1'b0, hi_ff});

   always_comb begin
      case (quad_rd_ff)
         QUAD_0: begin
            cos_val = hi_s;
            sin_val = lo_s;
         end
         QUAD_1: begin
            cos_val = -lo_s;
            sin_val = hi_s;
         end
         QUAD_2: begin
            cos_val = -hi_s;
            sin_val = -lo_s;
         end
         default: begin
            cos_val = lo_s;
            sin_val = -hi_s;
         end
      endcase
   end

endmodule

// ===== sv/lmpi_color_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_color_lane
// Complex rotation of one color component: four products, then add, round
// and saturate, or pass the component through.
// ----------------------------------------------------------------------------
module lmpi_color_lane
   import lmpi_pkg::*;
(
   input  logic                         clock,
   input  logic [NSTG:1]                stage_en,
   input  logic                         apply,
   input  logic signed [COMP_BITS-1:0]  in_re,
   input  logic signed [COMP_BITS-1:0]  in_im,
   input  logic signed [TRIG_BITS-1:0]  cos_val,
   input  logic signed [TRIG_BITS-1:0]  sin_val,
   output logic signed [COMP_BITS-1:0]  out_re,
   output logic signed [COMP_BITS-1:0]  out_im
);

   logic signed [PROD_BITS-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [COMP_BITS-1:0] re_ff, im_ff;
   logic                        apply_ff;
   logic signed [SUM_BITS-1:0]  re_sum, im_sum;
   logic signed [COMP_BITS-1:0] out_re_ff, out_im_ff;

   always_ff @(posedge clock) begin
      if (stage_en[STG_PROD]) begin
         ac_ff    <= in_re * cos_val;
         bs_ff    <= in_im * sin_val;
         as_ff    <= in_re * sin_val;
         bc_ff    <= in_im * cos_val;
         re_ff    <= in_re;
         im_ff    <= in_im;
         apply_ff <= apply;
      end
   end

   assign re_sum = SUM_BITS'(ac_ff) - SUM_BITS'(bs_ff);
   assign im_sum = SUM_BITS'(as_ff) + SUM_BITS'(bc_ff);

   always_ff @(posedge clock) begin
      if (stage_en[STG_OUT]) begin
         out_re_ff <= apply_ff ? sat_round(re_sum) : re_ff;
         out_im_ff <= apply_ff ? sat_round(im_sum) : im_ff;
      end
   end

   assign out_re = out_re_ff;
   assign out_im = out_im_ff;

endmodule

// ===== sv/lmpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_checker
// Port-level checks on the phase insertion unit, bound to the top level.
// ----------------------------------------------------------------------------
module lmpi_checker
   import lmpi_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COMP_BITS-1:0]  rsp_out_re0,
   input logic signed [COMP_BITS-1:0]  rsp_out_im0,
   input logic signed [COMP_BITS-1:0]  rsp_out_re1,
   input logic signed [COMP_BITS-1:0]  rsp_out_im1,
   input logic signed [COMP_BITS-1:0]  rsp_out_re2,
   input logic signed [COMP_BITS-1:0]  rsp_out_im2
);

   // reset leaves no word in flight
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // input only backs up when the output word is stuck
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without output backpressure");

   // a draining output always frees a slot
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_re0) && $stable(rsp_out_im0) &&
          $stable(rsp_out_re1) && $stable(rsp_out_im1) &&
          $stable(rsp_out_re2) && $stable(rsp_out_im2)))
      else $error("stalled rsp word changed");

endmodule

bind lattice_momentum_phase_insert_unit lmpi_checker u_lmpi_checker (.*);

// ===== bench/lmpi_phase_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpi_phase_checker
// Watches the csr, req and rsp ports of the phase insertion unit. It mirrors
// the register writes and computes the rotated vector for every accepted site.
// Each rsp word is compared field by field with the oldest pending vector.
// ----------------------------------------------------------------------------
module lmpi_phase_checker
   import lmpi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_wen,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,

   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_coord_x,
   input  logic [COORD_BITS-1:0]    req_coord_y,
   input  logic [COORD_BITS-1:0]    req_coord_z,
   input  logic [SLICE_BITS-1:0]    req_coord_t,
   input  logic [COMP_BITS-1:0]     req_in_re0,
   input  logic [COMP_BITS-1:0]     req_in_im0,
   input  logic [COMP_BITS-1:0]     req_in_re1,
   input  logic [COMP_BITS-1:0]     req_in_im1,
   input  logic [COMP_BITS-1:0]     req_in_re2,
   input  logic [COMP_BITS-1:0]     req_in_im2,

   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [COMP_BITS-1:0]     rsp_out_re0,
   input  logic [COMP_BITS-1:0]     rsp_out_im0,
   input  logic [COMP_BITS-1:0]     rsp_out_re1,
   input  logic [COMP_BITS-1:0]     rsp_out_im1,
   input  logic [COMP_BITS-1:0]     rsp_out_re2,
   input  logic [COMP_BITS-1:0]     rsp_out_im2,

   output int                       fail_count,
   output int                       pending
);

   localparam int MAX_PRINTED = 100;

   typedef longint unsigned u64_type;
   typedef logic [COMP_BITS-1:0] comp_type;

   typedef struct packed {
      comp_type [NCOLOR-1:0] re;
      comp_type [NCOLOR-1:0] im;
   } color_vec_type;

   typedef struct packed {
      logic [MOM_BITS-1:0]   mom_x;
      logic [MOM_BITS-1:0]   mom_y;
      logic [MOM_BITS-1:0]   mom_z;
      logic [EXT_BITS-1:0]   ext_x;
      logic [EXT_BITS-1:0]   ext_y;
      logic [EXT_BITS-1:0]   ext_z;
      logic [SLICE_BITS-1:0] slice;
      logic                  all_slices;
   } phase_cfg_type;

   phase_cfg_type cfg;
   int            sine_tab [0:QTR];
   color_vec_type rotated_q [$];

   // integer Taylor series in Q30, rounded to Q1.14
   function automatic int quarter_sine(int k);
      u64_type x;
      u64_type x2;
      u64_type term;
      longint  acc;
      longint  q;
      x    = (HALFPI_Q30 * u64_type'(k)) / u64_type'(QTR);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
         term = (term * x2) >> 30;
         term = term / (u64_type'(2 * n) * u64_type'(2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (acc + 32768) >>> 16;
      if (q > 16384) q = 16384;
      return int'(q);
   endfunction

   // fraction of a turn for one axis, rounded half up
   function automatic longint axis_phase(logic [MOM_BITS-1:0] m,
                                         logic [COORD_BITS-1:0] c,
                                         logic [EXT_BITS-1:0] n);
      longint p;
      longint r;
      longint nn;
      if (n == 0) return 0;
      nn = longint'(n);
      p  = longint'($signed(m)) * longint'(c);
      r  = p % nn;
      if (r < 0) r = r + nn;
      return ((r << (PHASE_BITS + 1)) + nn) / (2 * nn);
   endfunction

   function automatic comp_type round_sat(longint s);
      longint v;
      v = (s + (1 << (FRAC - 1))) >>> FRAC;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return comp_type'(v);
   endfunction

   function automatic color_vec_type rotate_colors(phase_cfg_type c,
                                                   logic [COORD_BITS-1:0] x,
                                                   logic [COORD_BITS-1:0] y,
                                                   logic [COORD_BITS-1:0] z,
                                                   logic [SLICE_BITS-1:0] t,
                                                   color_vec_type v);
      color_vec_type          o;
      longint                 tot;
      logic [PHASE_BITS-1:0]  ph;
      logic [1:0]             quad;
      int                     rsel;
      longint                 lo;
      longint                 hi;
      longint                 cs;
      longint                 sn;
      longint                 a;
      longint                 b;
      if (!(c.all_slices || t == c.slice)) return v;
      if (c.mom_x == 0 && c.mom_y == 0 && c.mom_z == 0) return v;
      tot  = axis_phase(c.mom_x, x, c.ext_x) + axis_phase(c.mom_y, y, c.ext_y) +
             axis_phase(c.mom_z, z, c.ext_z);
      ph   = tot[PHASE_BITS-1:0];
      quad = ph[PHASE_BITS-1 -: 2];
      rsel = int'(ph[ADDR_BITS-1:0]);
      lo   = sine_tab[rsel];
      hi   = sine_tab[QTR - rsel];
      case (quad)
         QUAD_0: begin cs = hi;  sn = lo;  end
         QUAD_1: begin cs = -lo; sn = hi;  end
         QUAD_2: begin cs = -hi; sn = -lo; end
         default: begin cs = lo; sn = -hi; end
      endcase
      for (int k = 0; k < NCOLOR; k++) begin
         a = longint'($signed(v.re[k]));
         b = longint'($signed(v.im[k]));
         o.re[k] = round_sat(a * cs - b * sn);
         o.im[k] = round_sat(a * sn + b * cs);
      end
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      if (fail_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   initial begin
      for (int k = 0; k <= QTR; k++) sine_tab[k] = quarter_sine(k);
   end

   always @(posedge clock) begin
      color_vec_type in_vec;
      color_vec_type got;
      color_vec_type want;
      if (reset) begin
         cfg <= '{mom_x: '0, mom_y: '0, mom_z: '0, ext_x: EXTENT_RESET,
                  ext_y: EXTENT_RESET, ext_z: EXTENT_RESET, slice: '0,
                  all_slices: 1'b0};
         rotated_q.delete();
         pending <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_MOM_X:      cfg.mom_x      <= csr_wdata[MOM_BITS-1:0];
               REG_MOM_Y:      cfg.mom_y      <= csr_wdata[MOM_BITS-1:0];
               REG_MOM_Z:      cfg.mom_z      <= csr_wdata[MOM_BITS-1:0];
               REG_EXTENT_X:   cfg.ext_x      <= csr_wdata[EXT_BITS-1:0];
               REG_EXTENT_Y:   cfg.ext_y      <= csr_wdata[EXT_BITS-1:0];
               REG_EXTENT_Z:   cfg.ext_z      <= csr_wdata[EXT_BITS-1:0];
               REG_SRC_SLICE:  cfg.slice      <= csr_wdata[SLICE_BITS-1:0];
               REG_ALL_SLICES: cfg.all_slices <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            in_vec.re = {req_in_re2, req_in_re1, req_in_re0};
            in_vec.im = {req_in_im2, req_in_im1, req_in_im0};
            rotated_q.push_back(rotate_colors(cfg, req_coord_x, req_coord_y,
                                              req_coord_z, req_coord_t, in_vec));
         end
         if (rsp_valid && rsp_ready) begin
            got.re = {rsp_out_re2, rsp_out_re1, rsp_out_re0};
            got.im = {rsp_out_im2, rsp_out_im1, rsp_out_im0};
            if (rotated_q.size() == 0) begin
               report_mismatch("rsp word with no site outstanding");
            end else begin
               want = rotated_q.pop_front();
               for (int k = 0; k < NCOLOR; k++) begin
                  if (got.re[k] !== want.re[k])
                     report_mismatch($sformatf("out_re%0d got %0d expected %0d", k,
                                     $signed(got.re[k]), $signed(want.re[k])));
                  if (got.im[k] !== want.im[k])
                     report_mismatch($sformatf("out_im%0d got %0d expected %0d", k,
                                     $signed(got.im[k]), $signed(want.im[k])));
               end
            end
         end
         pending <= rotated_q.size();
      end
   end

endmodule

// ===== bench/lattice_momentum_phase_insert_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_momentum_phase_insert_unit_tb
// Drives sites through the phase insertion unit under several register
// settings, with random gaps on req and random stalls on rsp. Checking is
// done by lmpi_phase_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module lattice_momentum_phase_insert_unit_tb;
   import lmpi_pkg::*;

   localparam int PIPE_LATENCY = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 7;
   localparam int RAND_PHASES  = 8;
   localparam int SITES_PER_PH = 60;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [SLICE_BITS-1:0] t;
      logic [COMP_BITS-1:0]  re0;
      logic [COMP_BITS-1:0]  im0;
      logic [COMP_BITS-1:0]  re1;
      logic [COMP_BITS-1:0]  im1;
      logic [COMP_BITS-1:0]  re2;
      logic [COMP_BITS-1:0]  im2;
   } site_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     csr_wen     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic [COORD_BITS-1:0]    req_coord_x = '0;
   logic [COORD_BITS-1:0]    req_coord_y = '0;
   logic [COORD_BITS-1:0]    req_coord_z = '0;
   logic [SLICE_BITS-1:0]    req_coord_t = '0;
   logic [COMP_BITS-1:0]     req_in_re0  = '0;
   logic [COMP_BITS-1:0]     req_in_im0  = '0;
   logic [COMP_BITS-1:0]     req_in_re1  = '0;
   logic [COMP_BITS-1:0]     req_in_im1  = '0;
   logic [COMP_BITS-1:0]     req_in_re2  = '0;
   logic [COMP_BITS-1:0]     req_in_im2  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   logic [COMP_BITS-1:0]     rsp_out_re0;
   logic [COMP_BITS-1:0]     rsp_out_im0;
   logic [COMP_BITS-1:0]     rsp_out_re1;
   logic [COMP_BITS-1:0]     rsp_out_im1;
   logic [COMP_BITS-1:0]     rsp_out_re2;
   logic [COMP_BITS-1:0]     rsp_out_im2;

   int fail_count;
   int pending;
   int cycles = 0;
   bit quiet  = 1'b0;   // no gaps or stalls while set

   lattice_momentum_phase_insert_unit DUT (.*);

   lmpi_phase_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

   function automatic logic [COMP_BITS-1:0] rand_comp();
      case ($urandom_range(9))
         0: return {1'b1, {(COMP_BITS - 1){1'b0}}};
         1: return {1'b0, {(COMP_BITS - 1){1'b1}}};
         2: return '0;
         default: return COMP_BITS'($urandom);
      endcase
   endfunction

   function automatic site_type rand_site(logic [SLICE_BITS-1:0] slice);
      site_type s;
      s.x   = COORD_BITS'($urandom);
      s.y   = COORD_BITS'($urandom);
      s.z   = COORD_BITS'($urandom);
      s.t   = ($urandom_range(1) == 0) ? slice : SLICE_BITS'($urandom);
      s.re0 = rand_comp();
      s.im0 = rand_comp();
      s.re1 = rand_comp();
      s.im1 = rand_comp();
      s.re2 = rand_comp();
      s.im2 = rand_comp();
      return s;
   endfunction

   task automatic send_site(site_type s);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_x <= s.x;
      req_coord_y <= s.y;
      req_coord_z <= s.z;
      req_coord_t <= s.t;
      req_in_re0  <= s.re0;
      req_in_im0  <= s.im0;
      req_in_re1  <= s.re1;
      req_in_im1  <= s.im1;
      req_in_re2  <= s.re2;
      req_in_im2  <= s.im2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // lets every accepted word come out before the registers move
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // unused upper data bits are randomized; the unit must ignore them
   task automatic load_phase_config(logic [MOM_BITS-1:0] mx, logic [MOM_BITS-1:0] my,
                                    logic [MOM_BITS-1:0] mz, logic [EXT_BITS-1:0] ex,
                                    logic [EXT_BITS-1:0] ey, logic [EXT_BITS-1:0] ez,
                                    logic [SLICE_BITS-1:0] slice, logic all);
      write_reg(REG_MOM_X, {1'($urandom), mx});
      write_reg(REG_MOM_Y, {1'($urandom), my});
      write_reg(REG_MOM_Z, {1'($urandom), mz});
      write_reg(REG_EXTENT_X, ex);
      write_reg(REG_EXTENT_Y, ey);
      write_reg(REG_EXTENT_Z, ez);
      write_reg(REG_SRC_SLICE, slice);
      write_reg(REG_ALL_SLICES, {6'($urandom), all});
      csr_wen <= 1'b0;
   endtask

   function automatic logic [EXT_BITS-1:0] rand_extent();
      case ($urandom_range(7))
         0: return '0;
         1: return EXT_BITS'($urandom_range(65, 127));
         default: return EXT_BITS'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      site_type s;
      logic [SLICE_BITS-1:0] slice;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero momentum, everything passes through
      send_site('0);
      send_site('{x: '1, y: '1, z: '1, t: '0, re0: 16'h8000, im0: 16'h7fff,
                  re1: 16'h7fff, im1: 16'h8000, re2: 16'hffff, im2: 16'h0001});
      send_site('{x: 6'h2a, y: 6'h15, z: 6'h3c, t: '1, re0: 16'h5555, im0: 16'haaaa,
                  re1: 16'h8000, im1: 16'h8000, re2: 16'h7fff, im2: 16'h7fff});
      drain_pipeline();

      // x steps through the quadrants and the 45 degree points on slice 5
      load_phase_config(6'd1, 6'd0, 6'd0, 7'd64, 7'd64, 7'd64, 7'd5, 1'b0);
      for (int i = 0; i < 8; i++) begin
         s = '{x: 6'(i * 8), y: '0, z: '0, t: 7'd5, re0: 16'h7fff, im0: 16'h7fff,
               re1: 16'h8000, im1: 16'h8000, re2: 16'h4000, im2: 16'h0000};
         send_site(s);
      end
      s.t = 7'd6;   // off the slice
      send_site(s);
      send_site('{x: '1, y: '1, z: '1, t: 7'd5, re0: 16'h8000, im0: 16'h7fff,
                  re1: 16'h0001, im1: 16'hffff, re2: 16'h7fff, im2: 16'h8000});
      drain_pipeline();

      // momentum extremes; extent zero, above 64, and coordinates past the extent
      load_phase_config(6'b100000, 6'b011111, 6'b111111, 7'd0, 7'd127, 7'd1,
                        7'd127, 1'b1);
      for (int i = 0; i < 5; i++) send_site(rand_site(7'd127));
      send_site('{x: '1, y: '1, z: '1, t: '0, re0: 16'h8000, im0: 16'h8000,
                  re1: 16'h7fff, im1: 16'h7fff, re2: 16'h8000, im2: 16'h7fff});
      drain_pipeline();

      load_phase_config(6'b011111, 6'b100000, 6'd0, 7'd64, 7'd1, 7'd63, 7'd0, 1'b0);
      for (int i = 0; i < 4; i++) begin
         s = rand_site(7'd0);
         s.t = (i % 2 == 0) ? 7'd0 : 7'd127;
         send_site(s);
      end
      drain_pipeline();

      for (int p = 0; p < RAND_PHASES; p++) begin
         slice = SLICE_BITS'($urandom);
         if (p == 2)
            load_phase_config('0, '0, '0, rand_extent(), rand_extent(), rand_extent(),
                              slice, 1'($urandom));
         else
            load_phase_config(MOM_BITS'($urandom), MOM_BITS'($urandom),
                              MOM_BITS'($urandom), rand_extent(), rand_extent(),
                              rand_extent(), slice, (p % 3 == 0));
         quiet = (p == 4);
         for (int i = 0; i < SITES_PER_PH; i++) send_site(rand_site(slice));
         drain_pipeline();
         quiet = 1'b0;
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lmpi_pkg.sv
sv/lmpi_axis_lane.sv
sv/lmpi_phase_merge.sv
sv/lmpi_color_lane.sv
sv/lattice_momentum_phase_insert_unit.sv
sv/lmpi_checker.sv
bench/lmpi_phase_checker.sv
bench/lattice_momentum_phase_insert_unit_tb.sv
